FILE: hw/rtl/kmp_pkg.sv
// Shared types and constants of the streaming KMP matcher.
package kmp_pkg;

  localparam int TEXT_W      = 8;
  localparam int START_W     = 16;
  localparam int COUNT_W     = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int PLEN_W      = 5;

  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 2'd2;

  typedef struct packed {
    logic [TEXT_W-1:0] text_byte;
    logic              last_byte;
  } kmp_in_t;

  typedef struct packed {
    logic               match_found;
    logic [START_W-1:0] match_start;
    logic [COUNT_W-1:0] match_count;
    logic               text_done;
  } kmp_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic build_start;
    logic build_sel;
    logic build_step;
    logic build_end;
    logic load;
    logic walk_step;
    logic finish;
  } kmp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic build_done;
    logic walk;
  } kmp_stat_t;

endpackage

FILE: hw/rtl/kmp_stream_matcher.sv
// Top level of the streaming Knuth-Morris-Pratt matcher.
// Text bytes enter on the in_ channel and each one yields one result on the out_ channel:
// a match flag, the start position of the match and the running count for the current
// text; a byte flagged last closes the text and clears position, count and match state.
// A byte is accepted, then resolved after any failure-link hops through the prefix table,
// which is read through a single port. Results sit in an output register, so the next
// byte is accepted while a result waits to be taken. Every write to a pattern register
// rebuilds the prefix table, one step per cycle; in_stall stays high during the rebuild.
// cfg_ready is low while a byte is being resolved.
module kmp_stream_matcher #(
  parameter int MAX_PATTERN   = 16,
  parameter int POSITION_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  kmp_pkg::kmp_in_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output kmp_pkg::kmp_out_t                  out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [kmp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [kmp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  kmp_pkg::kmp_cmd_t  cmd;
  kmp_pkg::kmp_stat_t stat;

  kmp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .stat      (stat),
    .cmd       (cmd)
  );

  kmp_datapath #(
    .MAX_PATTERN   (MAX_PATTERN),
    .POSITION_BITS (POSITION_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data)
  );

endmodule

FILE: hw/rtl/kmp_ctrl.sv
// Controller state machine of the KMP matcher: table build, byte matching, output slot.
module kmp_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  output logic                               out_valid,
  input  logic                               out_stall,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [kmp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  kmp_pkg::kmp_stat_t                 stat,
  output kmp_pkg::kmp_cmd_t                  cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_BUILD = 2'd1;
  localparam logic [1:0] ST_MATCH = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       cfg_hit;
  logic       slot_free;

  assign cfg_hit = cfg_valid && ((cfg_index == kmp_pkg::CFG_PATTERN_LOW) ||
                                 (cfg_index == kmp_pkg::CFG_PATTERN_HIGH) ||
                                 (cfg_index == kmp_pkg::CFG_PATTERN_LENGTH));
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.build_sel = (state_r == ST_BUILD);
    case (state_r)
      ST_IDLE: begin
        if (cfg_hit) begin
          cmd.build_start = 1'b1;
          state_nxt       = ST_BUILD;
        end else if (in_valid && !cfg_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MATCH;
        end
      end
      ST_BUILD: begin
        if (cfg_hit) begin
          cmd.build_start = 1'b1;
        end else if (stat.build_done) begin
          cmd.build_end = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cmd.build_step = 1'b1;
        end
      end
      ST_MATCH: begin
        if (stat.walk) begin
          cmd.walk_step = 1'b1;
        end else if (slot_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A configuration request in flight also holds off text bytes.
  assign in_stall  = (state_r != ST_IDLE) || cfg_valid;
  // Pattern writes wait while a byte is being resolved; a rebuild simply restarts.
  assign cfg_ready = (state_r != ST_MATCH);
  assign out_valid = out_valid_r;

endmodule

FILE: hw/rtl/kmp_datapath.sv
// Datapath of the KMP matcher: pattern registers, prefix table, match state and result register.
module kmp_datapath #(
  parameter int MAX_PATTERN   = 16,
  parameter int POSITION_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  kmp_pkg::kmp_cmd_t                  cmd,
  output kmp_pkg::kmp_stat_t                 stat,
  input  logic [kmp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [kmp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  kmp_pkg::kmp_in_t                   in_data,
  output kmp_pkg::kmp_out_t                  out_data
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int PW    = POSITION_BITS;
  localparam logic [PW-1:0] POS_MAX   = {PW{1'b1}};
  localparam logic [PW:0]   START_MAX = (PW+1)'(33'h0_0000_FFFF);
  localparam logic [kmp_pkg::COUNT_W-1:0] COUNT_MAX = {kmp_pkg::COUNT_W{1'b1}};

  logic [kmp_pkg::CFG_DATA_W-1:0] pat_low_r;
  logic [kmp_pkg::CFG_DATA_W-1:0] pat_high_r;
  logic [kmp_pkg::PLEN_W-1:0]     plen_r;

  logic [LEN_W-1:0]  pfx_r [MAX_PATTERN];
  logic [LEN_W-1:0]  border_r;
  logic [LEN_W-1:0]  i_r;
  logic [LEN_W-1:0]  k_r;
  logic [PW-1:0]     pos_r;
  logic [kmp_pkg::COUNT_W-1:0] count_r;
  logic [kmp_pkg::TEXT_W-1:0]  c_r;
  logic              last_r;
  kmp_pkg::kmp_out_t out_r;

  logic [2*kmp_pkg::CFG_DATA_W-1:0] pat_word;
  logic [kmp_pkg::TEXT_W-1:0] pat_w [MAX_PATTERN];
  logic [LEN_W-1:0]  len_w;
  logic [kmp_pkg::TEXT_W-1:0] cmp_byte;
  logic              eq;
  logic [LEN_W-1:0]  km1;
  logic [LEN_W-1:0]  pfx_rd;
  logic [LEN_W-1:0]  k_inc;
  logic              found;
  logic [PW:0]       start_w;
  logic [kmp_pkg::COUNT_W-1:0] count_inc;

  assign pat_word = {pat_high_r, pat_low_r};

  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      pat_w[j] = pat_word[kmp_pkg::TEXT_W*j +: kmp_pkg::TEXT_W];
    end
  end

  // Length in use: zero counts as one, anything above the table depth is clipped.
  always_comb begin
    if (plen_r == '0) begin
      len_w = LEN_W'(1);
    end else if (plen_r > kmp_pkg::PLEN_W'(MAX_PATTERN)) begin
      len_w = LEN_W'(MAX_PATTERN);
    end else begin
      len_w = LEN_W'(plen_r);
    end
  end

  // One comparator serves both the table build and the text match.
  assign cmp_byte = cmd.build_sel ? pat_w[i_r[IDX_W-1:0]] : c_r;
  assign eq       = (pat_w[k_r[IDX_W-1:0]] == cmp_byte);
  assign km1      = k_r - LEN_W'(1);
  assign pfx_rd   = pfx_r[km1[IDX_W-1:0]];
  assign k_inc    = eq ? (k_r + LEN_W'(1)) : k_r;
  assign found    = (k_inc == len_w);
  assign start_w  = {1'b0, pos_r} + (PW+1)'(1) - (PW+1)'(len_w);
  assign count_inc = (found && (count_r != COUNT_MAX)) ? (count_r + 1'b1) : count_r;

  assign stat.walk       = (k_r != '0) && !eq;
  assign stat.build_done = (i_r >= len_w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      plen_r     <= kmp_pkg::PLEN_W'(1);
    end else if (cmd.build_start) begin
      case (cfg_index)
        kmp_pkg::CFG_PATTERN_LOW:    pat_low_r  <= cfg_data;
        kmp_pkg::CFG_PATTERN_HIGH:   pat_high_r <= cfg_data;
        kmp_pkg::CFG_PATTERN_LENGTH: plen_r     <= cfg_data[kmp_pkg::PLEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Prefix table build, one step per cycle: either a failure-link hop or one new entry.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.build_start) begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
        pfx_r[j] <= '0;
      end
      border_r <= '0;
      i_r      <= LEN_W'(1);
    end else if (cmd.build_step) begin
      if (!stat.walk) begin
        pfx_r[i_r[IDX_W-1:0]] <= k_inc;
        if ((i_r + LEN_W'(1)) == len_w) begin
          border_r <= k_inc;
        end
        i_r <= i_r + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= '0;
      pos_r   <= '0;
      count_r <= '0;
    end else if (cmd.build_start || cmd.build_end) begin
      k_r <= '0;
    end else if (cmd.build_step || cmd.walk_step) begin
      k_r <= stat.walk ? pfx_rd : k_inc;
    end else if (cmd.load) begin
      if (k_r >= len_w) begin
        k_r <= '0;
      end
    end else if (cmd.finish) begin
      if (last_r) begin
        k_r     <= '0;
        pos_r   <= '0;
        count_r <= '0;
      end else begin
        k_r     <= found ? border_r : k_inc;
        count_r <= count_inc;
        if (pos_r != POS_MAX) begin
          pos_r <= pos_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_r    <= in_data.text_byte;
      last_r <= in_data.last_byte;
    end
    if (cmd.finish) begin
      out_r.match_found <= found;
      if (!found) begin
        out_r.match_start <= '0;
      end else if (start_w > START_MAX) begin
        out_r.match_start <= {kmp_pkg::START_W{1'b1}};
      end else begin
        out_r.match_start <= kmp_pkg::START_W'(start_w);
      end
      out_r.match_count <= count_inc;
      out_r.text_done   <= last_r;
    end
  end

  assign out_data = out_r;

endmodule
